/* rtl/core/sl50_pkg.sv */
// shared types and constants for the sequence length / n50 statistics block
// no dependencies
package sl50_pkg;

	localparam int MAX_SEQUENCES_DEF = 1024;
	localparam int LENGTH_BITS_DEF   = 32;

	// fixed port field widths
	localparam int PORT_LEN_W = 32;
	localparam int PORT_CNT_W = 11;
	localparam int OUT_DATA_W = 144;

	typedef struct packed {
		logic busy;
		logic done;
	} sl50_div_stat_t;

endpackage

/* rtl/core/sl50_len_store.sv */
// length store: one write port, one registered read port
// depends on sl50_pkg
module sl50_len_store import sl50_pkg::*; #(
	parameter int DEPTH  = MAX_SEQUENCES_DEF,
	parameter int DATA_W = LENGTH_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/sl50_divider.sv */
// restoring divider, one quotient bit per cycle
// depends on sl50_pkg
module sl50_divider import sl50_pkg::*; #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output sl50_div_stat_t   stat
);

	localparam int IW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [IW-1:0]    iter_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= IW'(NUM_W);
		end else if (busy_q) begin
			iter_q <= iter_q - 1'b1;
			if (iter_q == IW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* rtl/core/sequence_length_n50_stats.sv */
// sequence length statistics with n50
// loading takes one word per cycle while in the load state (s_tready is low from the
// word marked last until the result word is issued). after the last word, n50 is found by
// scan passes over the length store: each pass picks the next smaller distinct length;
// the average comes from a bit-serial divider run alongside. no reset of the store.
module sequence_length_n50_stats import sl50_pkg::*; #(
	parameter int MAX_SEQUENCES = MAX_SEQUENCES_DEF,
	parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [PORT_LEN_W-1:0] s_tdata,  // seq_length[31:0]
	input  logic                  s_tlast,  // last_item
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// seq_count[10:0] avg_length[42:11] min_length[74:43] max_length[106:75]
	// n50_length[138:107] overflow[139] zero[143:140]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(MAX_SEQUENCES);
	localparam int CW = $clog2(MAX_SEQUENCES + 1);
	localparam int LW = LENGTH_BITS;
	localparam int TW = LENGTH_BITS + CW;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_PEND = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t st_q;

	// set accumulation
	logic [CW-1:0] cnt_q;
	logic [TW-1:0] tot_q;
	logic [LW-1:0] min_q, max_q;
	logic          ovf_q;

	// latched set for the scan
	logic [CW-1:0] n_q;
	logic [TW-1:0] half_q;
	logic [LW-1:0] smin_q, smax_q;
	logic          sovf_q;

	// scan state
	logic [CW-1:0] idx_q;
	logic          issue_q;
	logic          rd_vld_s1, rd_last_s1;
	logic [LW-1:0] thr_q, cand_q, n50_q;
	logic          thr_inf_q, cand_vld_q;
	logic [TW-1:0] csum_q, acc_q;

	// result word held apart from the scan state so the next set can load
	logic [OUT_DATA_W-1:0] res_q;
	logic [LW-1:0] rdata;
	logic [TW-1:0] quo;
	sl50_div_stat_t div_st;

	logic          s_acc, store_ok, div_start, res_issue;
	logic [LW-1:0] len;
	logic [CW-1:0] cnt_new;
	logic [TW-1:0] tot_new, acc_new;
	logic          elig;

	assign s_tready  = (st_q == ST_LOAD);
	assign s_acc     = s_tvalid && s_tready;
	assign len       = LW'(s_tdata);
	assign store_ok  = cnt_q < CW'(MAX_SEQUENCES);
	assign cnt_new   = store_ok ? cnt_q + 1'b1 : cnt_q;
	assign tot_new   = store_ok ? tot_q + TW'(len) : tot_q;
	assign div_start = s_acc && s_tlast;
	assign acc_new   = acc_q + csum_q;
	assign elig      = thr_inf_q || (rdata < thr_q);
	assign res_issue = (st_q == ST_FIN) && div_st.done && (!m_tvalid || m_tready);

	sl50_len_store #(.DEPTH(MAX_SEQUENCES), .DATA_W(LW)) u_store (
		.clk   (clk),
		.we    (s_acc && store_ok),
		.waddr (cnt_q[AW-1:0]),
		.wdata (len),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	sl50_divider #(.NUM_W(TW), .DEN_W(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (tot_new),
		.den    (cnt_new),
		.quo    (quo),
		.stat   (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_LOAD;
			cnt_q      <= '0;
			tot_q      <= '0;
			ovf_q      <= 1'b0;
			issue_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			if (res_issue) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			rd_vld_s1  <= issue_q;
			rd_last_s1 <= issue_q && (idx_q == n_q - 1'b1);
			unique case (st_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (s_tlast) begin
							cnt_q   <= '0;
							tot_q   <= '0;
							ovf_q   <= 1'b0;
							issue_q <= 1'b1;
							st_q    <= ST_SCAN;
						end else begin
							cnt_q <= cnt_new;
							tot_q <= tot_new;
							ovf_q <= ovf_q || !store_ok;
						end
					end
				end
				ST_SCAN: begin
					if (issue_q && (idx_q == n_q - 1'b1)) begin
						issue_q <= 1'b0;
					end
					if (rd_last_s1) begin
						st_q <= ST_PEND;
					end
				end
				ST_PEND: begin
					if (acc_new >= half_q || !cand_vld_q) begin
						st_q <= ST_FIN;
					end else begin
						issue_q <= 1'b1;
						st_q    <= ST_SCAN;
					end
				end
				ST_FIN: begin
					if (res_issue) begin
						st_q <= ST_LOAD;
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && store_ok) begin
			if (cnt_q == '0) begin
				min_q <= len;
				max_q <= len;
			end else begin
				if (len < min_q) min_q <= len;
				if (len > max_q) max_q <= len;
			end
		end
		if (issue_q) begin
			idx_q <= idx_q + 1'b1;
		end
		unique case (st_q)
			ST_LOAD: begin
				if (div_start) begin
					n_q        <= cnt_new;
					half_q     <= tot_new >> 1;
					sovf_q     <= ovf_q || !store_ok;
					smin_q     <= (store_ok && (cnt_q == '0 || len < min_q)) ? len : min_q;
					smax_q     <= (store_ok && (cnt_q == '0 || len > max_q)) ? len : max_q;
					idx_q      <= '0;
					thr_inf_q  <= 1'b1;
					cand_vld_q <= 1'b0;
					csum_q     <= '0;
					acc_q      <= '0;
				end
			end
			ST_SCAN: begin
				// largest length below the threshold, and the sum of its copies
				if (rd_vld_s1 && elig) begin
					if (!cand_vld_q || rdata > cand_q) begin
						cand_q     <= rdata;
						cand_vld_q <= 1'b1;
						csum_q     <= TW'(rdata);
					end else if (rdata == cand_q) begin
						csum_q <= csum_q + TW'(rdata);
					end
				end
			end
			ST_PEND: begin
				n50_q      <= cand_q;
				thr_q      <= cand_q;
				thr_inf_q  <= 1'b0;
				acc_q      <= acc_new;
				cand_vld_q <= 1'b0;
				csum_q     <= '0;
				idx_q      <= '0;
			end
			ST_FIN: begin
				if (res_issue) begin
					res_q <= {4'b0, sovf_q, PORT_LEN_W'(n50_q), PORT_LEN_W'(smax_q),
						PORT_LEN_W'(smin_q), PORT_LEN_W'(quo), PORT_CNT_W'(n_q)};
				end
			end
			default: ;
		endcase
	end

	assign m_tdata = res_q;

	// a pass after the first always finds a smaller length before the total is used up
	a_cand: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PEND) |-> cand_vld_q)
		else $error("scan pass ended without a candidate");

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SEQUENCES))
		else $error("length count beyond store depth");

	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(div_st.done))
		else $error("result issued before division finished");

	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (st_q == ST_SCAN))
		else $error("store read data outside a scan pass");

endmodule

/* tb/sl50_checker.sv */
// result checker for sequence_length_n50_stats: watches both stream channels,
// predicts each set's statistics and compares them field by field (uses sl50_pkg)
`timescale 1ns / 100ps

module sl50_checker import sl50_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [PORT_LEN_W-1:0] s_tdata,
	input  logic                  s_tlast,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		logic [PORT_CNT_W-1:0] cnt;
		logic [31:0]           avg;
		logic [31:0]           mn;
		logic [31:0]           mx;
		logic [31:0]           n50;
		logic                  ovf;
	} set_stats_t;

	set_stats_t      stats_q[$];
	logic [31:0]     lengths [MAX_SEQUENCES_DEF];
	int unsigned     set_count;
	longint unsigned set_total;
	bit              set_ovf;

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic set_stats_t summarize();
		longint unsigned sorted[$];
		longint unsigned half;
		longint unsigned acc;
		set_stats_t r;
		for (int i = 0; i < set_count; i++)
			sorted.insert(sorted.size(), 64'(lengths[i]));
		sorted.rsort();
		r.cnt = PORT_CNT_W'(set_count);
		r.avg = 32'(set_total / set_count);
		r.mx  = 32'(sorted[0]);
		r.mn  = 32'(sorted[set_count-1]);
		r.ovf = set_ovf;
		r.n50 = '0;
		half  = set_total / 2;
		acc   = 0;
		for (int i = 0; i < set_count; i++) begin
			acc += sorted[i];
			if (acc >= half) begin
				r.n50 = 32'(sorted[i]);
				break;
			end
		end
		return r;
	endfunction

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		set_stats_t want;
		set_stats_t got;
		if (!arst_n) begin
			set_count = 0;
			set_total = 0;
			set_ovf   = 0;
			stats_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				if (set_count < MAX_SEQUENCES_DEF) begin
					lengths[set_count] = s_tdata;
					set_count++;
					set_total += s_tdata;
				end else begin
					set_ovf = 1;
				end
				if (s_tlast) begin
					stats_q.insert(stats_q.size(), summarize());
					set_count = 0;
					set_total = 0;
					set_ovf   = 0;
				end
			end
			if (m_tvalid && m_tready) begin
				got.cnt = m_tdata[10:0];
				got.avg = m_tdata[42:11];
				got.mn  = m_tdata[74:43];
				got.mx  = m_tdata[106:75];
				got.n50 = m_tdata[138:107];
				got.ovf = m_tdata[139];
				if (stats_q.size() == 0) begin
					report("result word with no set pending");
				end else begin
					want = stats_q.pop_front();
					if (got.cnt != want.cnt)
						report($sformatf("count %0d want %0d", got.cnt, want.cnt));
					if (got.avg != want.avg)
						report($sformatf("avg %0d want %0d", got.avg, want.avg));
					if (got.mn != want.mn)
						report($sformatf("min %0d want %0d", got.mn, want.mn));
					if (got.mx != want.mx)
						report($sformatf("max %0d want %0d", got.mx, want.mx));
					if (got.n50 != want.n50)
						report($sformatf("n50 %0d want %0d", got.n50, want.n50));
					if (got.ovf != want.ovf)
						report($sformatf("overflow %0d want %0d", got.ovf, want.ovf));
				end
			end
		end
		pending = stats_q.size();
	end

endmodule

/* tb/tb_top.sv */
// top of the sequence_length_n50_stats testbench: clock, reset, length sets
// and handshake pressure; checking lives in sl50_checker (uses sl50_pkg)
`timescale 1ns / 100ps

module tb_top;
	import sl50_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PORT_LEN_W-1:0] s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    errors;
	int                    pending;
	int                    idle_pct;
	int                    stall_pct;
	int                    words_sent;

	sequence_length_n50_stats u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sl50_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#50_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// one word per call; called and returns at a falling edge
	task automatic send_word(input logic [31:0] len, input bit last);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = len;
		s_tlast  = last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		words_sent++;
	endtask

	function automatic logic [31:0] pick_length(input int mode);
		case (mode)
			0: pick_length = $urandom;
			1: pick_length = $urandom_range(15);
			2: pick_length = 32'hFFFF_FFFF - $urandom_range(15);
			default: begin
				case ($urandom_range(3))
					0: pick_length = 32'h0;
					1: pick_length = 32'd5;
					2: pick_length = 32'd5000;
					default: pick_length = 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	task automatic send_set(input int n, input int mode);
		for (int i = 0; i < n; i++)
			send_word(pick_length(mode), i == n - 1);
	endtask

	// block may still be clearing after its result
	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin
		int n;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		m_tready   = 1'b0;
		idle_pct   = 0;
		stall_pct  = 0;
		words_sent = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: single words at the extremes, all zero, all max, ties
		send_word(32'h0, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'h0, 1'b0);
		send_word(32'h0, 1'b0);
		send_word(32'h0, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'd1, 1'b0);
		send_word(32'd2, 1'b0);
		send_word(32'd3, 1'b1);
		send_word(32'd7, 1'b0);
		send_word(32'd7, 1'b0);
		send_word(32'd7, 1'b0);
		send_word(32'd7, 1'b1);
		send_word(32'd1, 1'b0);
		send_word(32'd100, 1'b1);
		drain();

		// store filled and then overflowing; few distinct lengths keep it short
		send_set(MAX_SEQUENCES_DEF + 2, 3);
		drain();

		words_sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 71; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 71; end
				default: begin idle_pct = 19; stall_pct = 19; end
			endcase
			while (words_sent < (phase + 1) * 50) begin
				n = ($urandom_range(9) == 0) ? $urandom_range(40) + 1 : $urandom_range(12) + 1;
				send_set(n, $urandom_range(3));
			end
			drain();
		end

		idle_pct  = 0;
		stall_pct = 0;
		drain();
		repeat (50) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/sl50_pkg.sv
rtl/core/sl50_len_store.sv
rtl/core/sl50_divider.sv
rtl/core/sequence_length_n50_stats.sv
tb/sl50_checker.sv
tb/tb_top.sv
